// ===== hdl/sorted_priority_queue_unit_macros.svh =====
// Assertion macros shared by the queue modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The condition must hold at every clock edge out of reset.
`define SPQ_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue check failed");

`else

`define SPQ_ASSERT_ALWAYS(label, cond)
`define SPQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/spq_pkg.sv =====
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PRIO_W      = 8;
    localparam int DATA_W      = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_DELETE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        CTRL_IDLE = 1'b0,
        CTRL_HOLD = 1'b1
    } ctrl_state_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    insert;
        logic    remove;
        status_t code;
    } spq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
    } spq_stat_t;

    // Result held in the output register.
    typedef struct packed {
        status_t             status;
        logic                out_valid;
        logic [PRIO_W-1:0]   out_priority;
        logic [DATA_W-1:0]   out_payload;
        logic [COUNT_W-1:0]  occupancy;
    } spq_result_t;

endpackage

// ===== hdl/spq_req_if.sv =====
interface spq_req_if;

    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [spq_pkg::PRIO_W-1:0]   priority_req;
    logic [spq_pkg::DATA_W-1:0]   payload;

    modport source (output valid, output action, output priority_req, output payload,
                    input ready);
    modport sink   (input valid, input action, input priority_req, input payload,
                    output ready);

endinterface

// ===== hdl/spq_rsp_if.sv =====
interface spq_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic                          out_valid;
    logic [spq_pkg::PRIO_W-1:0]    out_priority;
    logic [spq_pkg::DATA_W-1:0]    out_payload;
    logic [spq_pkg::COUNT_W-1:0]   occupancy;

    modport source (output valid, output status, output out_valid, output out_priority,
                    output out_payload, output occupancy, input ready);
    modport sink   (input valid, input status, input out_valid, input out_priority,
                    input out_payload, input occupancy, output ready);

endinterface

// ===== hdl/spq_ctrl.sv =====
`include "sorted_priority_queue_unit_macros.svh"

module spq_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_action,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  spq_pkg::spq_stat_t  stat,
    output spq_pkg::spq_cmd_t   cmd
);

    spq_pkg::ctrl_state_t state_reg;
    spq_pkg::ctrl_state_t state_next;
    logic                 accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::CTRL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        unique case (state_reg)
            spq_pkg::CTRL_IDLE:
            begin
                req_ready = 1'b1;
            end
            spq_pkg::CTRL_HOLD:
            begin
                rsp_valid = 1'b1;
                // The output register frees up this cycle when the result is taken.
                req_ready = rsp_ready;
                if (rsp_ready)
                begin
                    state_next = spq_pkg::CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::CTRL_IDLE;
            end
        endcase

        accept = req_valid && req_ready;
        if (accept)
        begin
            state_next = spq_pkg::CTRL_HOLD;
        end

        cmd.load   = accept;
        cmd.insert = 1'b0;
        cmd.remove = 1'b0;
        cmd.code   = spq_pkg::STATUS_OK;
        unique case (spq_pkg::action_t'(req_action))
            spq_pkg::ACT_INSERT:
            begin
                cmd.insert = accept && !stat.full;
                cmd.code   = stat.full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_OK;
            end
            spq_pkg::ACT_DELETE:
            begin
                cmd.remove = accept && !stat.empty;
                cmd.code   = stat.empty ? spq_pkg::STATUS_EMPTY : spq_pkg::STATUS_OK;
            end
            default:
            begin
                cmd.code = spq_pkg::STATUS_OK;
            end
        endcase
    end

    `SPQ_ASSERT_NEXT(a_load_holds_result, cmd.load, state_reg == spq_pkg::CTRL_HOLD)
    `SPQ_ASSERT_ALWAYS(a_single_op, !(cmd.insert && cmd.remove))
    `SPQ_ASSERT_ALWAYS(a_ready_when_idle, (state_reg != spq_pkg::CTRL_IDLE) || req_ready)

endmodule

// ===== hdl/spq_datapath.sv =====
`include "sorted_priority_queue_unit_macros.svh"

module spq_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  spq_pkg::spq_cmd_t                   cmd,
    input  logic [spq_pkg::PRIO_W-1:0]          in_priority,
    input  logic [spq_pkg::DATA_W-1:0]          in_payload,
    output spq_pkg::spq_stat_t                  stat,
    output spq_pkg::spq_result_t                result
);

    logic [spq_pkg::PRIO_W-1:0]  slot_prio_reg [spq_pkg::QUEUE_DEPTH];
    logic [spq_pkg::DATA_W-1:0]  slot_data_reg [spq_pkg::QUEUE_DEPTH];
    logic [spq_pkg::PRIO_W-1:0]  slot_prio_next [spq_pkg::QUEUE_DEPTH];
    logic [spq_pkg::DATA_W-1:0]  slot_data_next [spq_pkg::QUEUE_DEPTH];
    logic [spq_pkg::QUEUE_DEPTH-1:0] stay;
    logic [spq_pkg::COUNT_W-1:0] count_reg;
    logic [spq_pkg::COUNT_W-1:0] count_next;
    spq_pkg::spq_result_t        result_reg;

    assign stat.full  = (count_reg == spq_pkg::COUNT_W'(spq_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    // Every slot decides in parallel whether it keeps its entry, takes the new one,
    // or takes its neighbor's. Slots that keep their entry form a prefix.
    always_comb
    begin
        for (int i = 0; i < spq_pkg::QUEUE_DEPTH; i++)
        begin
            stay[i] = (spq_pkg::COUNT_W'(i) < count_reg) && (slot_prio_reg[i] >= in_priority);
        end

        for (int i = 0; i < spq_pkg::QUEUE_DEPTH; i++)
        begin
            slot_prio_next[i] = slot_prio_reg[i];
            slot_data_next[i] = slot_data_reg[i];
            if (cmd.insert && !stay[i])
            begin
                if (i == 0)
                begin
                    slot_prio_next[i] = in_priority;
                    slot_data_next[i] = in_payload;
                end
                else if (stay[i-1])
                begin
                    slot_prio_next[i] = in_priority;
                    slot_data_next[i] = in_payload;
                end
                else
                begin
                    slot_prio_next[i] = slot_prio_reg[i-1];
                    slot_data_next[i] = slot_data_reg[i-1];
                end
            end
            else if (cmd.remove && (i < spq_pkg::QUEUE_DEPTH - 1))
            begin
                slot_prio_next[i] = slot_prio_reg[i+1];
                slot_data_next[i] = slot_data_reg[i+1];
            end
        end

        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.remove)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < spq_pkg::QUEUE_DEPTH; i++)
        begin
            slot_prio_reg[i] <= slot_prio_next[i];
            slot_data_reg[i] <= slot_data_next[i];
        end
        if (cmd.load)
        begin
            result_reg.status       <= cmd.code;
            result_reg.out_valid    <= cmd.remove;
            result_reg.out_priority <= cmd.remove ? slot_prio_reg[0] : '0;
            result_reg.out_payload  <= cmd.remove ? slot_data_reg[0] : '0;
            result_reg.occupancy    <= count_next;
        end
    end

    assign result = result_reg;

    `SPQ_ASSERT_ALWAYS(a_count_bound,
        count_reg <= spq_pkg::COUNT_W'(spq_pkg::QUEUE_DEPTH))
    `SPQ_ASSERT_NEXT(a_insert_counts, cmd.insert, count_reg == $past(count_reg) + 1'b1)
    `SPQ_ASSERT_NEXT(a_remove_head, cmd.remove,
        result_reg.out_valid && (result_reg.out_priority == $past(slot_prio_reg[0])))

endmodule

// ===== hdl/sorted_priority_queue_unit.sv =====
// Sorted priority queue of QUEUE_DEPTH entries, each a priority and a data tag.
// Requests arrive on the req channel: action 0 inserts an entry behind every
// stored entry of equal or higher priority, action 1 removes the entry of
// highest priority. Every request yields exactly one response on the rsp
// channel with a status (ok, full, or empty), the removed entry when there was
// one, and the number of entries held afterwards.
// The response is valid in the cycle after the request is accepted. Throughput is
// one request per cycle while each response is taken as it appears; it is set by
// the row of slot registers, which all compare against the new priority and shift.
// The response sits in an output register; a new request is accepted in the
// same cycle the held response is taken, so a stalled receiver stalls the req
// channel and nothing is lost or repeated.
// Reset clears the entry count and the controller; the slot contents are left
// as they are, since only slots below the count are ever read.
module sorted_priority_queue_unit
(
    input  logic clk,
    input  logic rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    spq_pkg::spq_cmd_t    cmd;
    spq_pkg::spq_stat_t   stat;
    spq_pkg::spq_result_t result;

    // The controller owns the handshakes and turns each accepted request
    // into a datapath command.
    spq_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req.action),
        .req_ready  (req.ready),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // The datapath holds the sorted slots, the count and the response register.
    spq_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_priority (req.priority_req),
        .in_payload  (req.payload),
        .stat        (stat),
        .result      (result)
    );

    assign rsp.status       = result.status;
    assign rsp.out_valid    = result.out_valid;
    assign rsp.out_priority = result.out_priority;
    assign rsp.out_payload  = result.out_payload;
    assign rsp.occupancy    = result.occupancy;

endmodule

// ===== dv/sorted_priority_queue_checker.sv =====
`timescale 1ns / 100ps

module sorted_priority_queue_checker
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if        req,
    spq_rsp_if        rsp,
    output int        outstanding,
    output int        mismatches
);

    // Shadow copy of the sorted slots; slot 0 holds the highest priority.
    logic [PRIO_W-1:0] shadow_prio [QUEUE_DEPTH];
    logic [DATA_W-1:0] shadow_data [QUEUE_DEPTH];
    int                shadow_count;

    // Responses owed by the block, oldest first.
    spq_result_t       due_responses [$];

    function automatic spq_result_t serve_request(action_t act, logic [PRIO_W-1:0] prio,
                                                  logic [DATA_W-1:0] data);
        spq_result_t r;
        int          pos;
        int          i;
        r        = '0;
        r.status = STATUS_OK;
        if (act == ACT_INSERT)
        begin
            if (shadow_count >= QUEUE_DEPTH)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] >= prio)
                    pos++;
                for (i = shadow_count; i > pos; i--)
                begin
                    shadow_prio[i] = shadow_prio[i-1];
                    shadow_data[i] = shadow_data[i-1];
                end
                shadow_prio[pos] = prio;
                shadow_data[pos] = data;
                shadow_count++;
            end
        end
        else if (shadow_count == 0)
        begin
            r.status = STATUS_EMPTY;
        end
        else
        begin
            r.out_valid    = 1'b1;
            r.out_priority = shadow_prio[0];
            r.out_payload  = shadow_data[0];
            for (i = 1; i < shadow_count; i++)
            begin
                shadow_prio[i-1] = shadow_prio[i];
                shadow_data[i-1] = shadow_data[i];
            end
            shadow_count--;
        end
        r.occupancy = COUNT_W'(shadow_count);
        return r;
    endfunction

    function automatic int check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        spq_result_t want;
        int          errs;
        if (!rst_n)
        begin
            shadow_count = 0;
            due_responses.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            errs = 0;
            // A response taken now belongs to a request accepted at an earlier edge,
            // so it is matched before this edge's request is predicted.
            if (rsp.valid && rsp.ready)
            begin
                if (due_responses.size() == 0)
                begin
                    $error("response seen with no request outstanding");
                    errs++;
                end
                else
                begin
                    want = due_responses.pop_front();
                    errs += check_field("status", want.status, rsp.status);
                    errs += check_field("out_valid", want.out_valid, rsp.out_valid);
                    errs += check_field("out_priority", want.out_priority, rsp.out_priority);
                    errs += check_field("out_payload", want.out_payload, rsp.out_payload);
                    errs += check_field("occupancy", want.occupancy, rsp.occupancy);
                end
            end
            if (req.valid && req.ready)
                due_responses.push_back(serve_request(action_t'(req.action),
                                                      req.priority_req, req.payload));
            outstanding <= due_responses.size();
            mismatches  <= mismatches + errs;
        end
    end

endmodule

// ===== dv/tb_sorted_priority_queue_unit.sv =====
`timescale 1ns / 100ps

module tb_sorted_priority_queue_unit;

    import spq_pkg::*;

    // Number of random requests after the directed opening.
    localparam int RANDOM_REQUESTS = 600;
    // Cycles with no request and no response taken before the run is abandoned.
    // The longest legal quiet stretch is a sender gap or a receiver stall,
    // so this is far beyond any correct run.
    localparam int IDLE_LIMIT      = 2000;
    // Extra cycles to wait once nothing is owed.
    localparam int DRAIN_CYCLES    = 4;

    // Request mix of a random phase: mostly inserts to push the queue toward full,
    // mostly deletes to pull it toward empty, or an even blend.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } request_mix_t;

    // How the response side takes results during a stretch of cycles.
    typedef enum int {
        SINK_STEADY,
        SINK_CHOPPY,
        SINK_PERIODIC
    } sink_style_t;

    logic clk = 1'b0;
    logic rst_n;

    int outstanding;
    int mismatches;

    spq_req_if req_ch();
    spq_rsp_if rsp_ch();

    sorted_priority_queue_unit i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // The checker watches both channels, keeps its own sorted copy of the queue
    // and reports how many responses are still owed and how many fields were wrong.
    sorted_priority_queue_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Drive one request and hold it until the block takes it. The task returns at
    // the edge where valid and ready were both high, so a following call keeps
    // valid high without a gap and without a second assignment in that step.
    task automatic issue_request(action_t act, logic [PRIO_W-1:0] prio,
                                 logic [DATA_W-1:0] data);
        req_ch.valid        <= 1'b1;
        req_ch.action       <= act;
        req_ch.priority_req <= prio;
        req_ch.payload      <= data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Leave the request channel quiet for a number of cycles.
    task automatic hold_off(int cycles);
        if (cycles > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every response owed has been taken. One edge
    // passes first so that a request accepted at the current edge is counted.
    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Pick one random request for the given mix. Half of the priorities come
    // from four spread values so that ties, and with them the first-in,
    // first-out order among equal priorities, show up often. Deletes carry
    // random priority and payload bits, which the block must ignore.
    task automatic issue_random_request(request_mix_t mix);
        action_t           act;
        logic [PRIO_W-1:0] prio;
        int                insert_weight;
        case (mix)
            MIX_FILL:  insert_weight = 80;
            MIX_DRAIN: insert_weight = 20;
            default:   insert_weight = 50;
        endcase
        act = ($urandom_range(0, 99) < insert_weight) ? ACT_INSERT : ACT_DELETE;
        if ($urandom_range(0, 1) == 0)
            prio = PRIO_W'($urandom_range(0, 255));
        else
            prio = PRIO_W'($urandom_range(0, 3) * 85);
        issue_request(act, prio, DATA_W'($urandom));
    endtask

    // Response side: every so often it switches between always ready, random
    // stalls and a fixed stall pattern, so stalls land on every kind of request.
    sink_style_t sink_style = SINK_STEADY;
    int          sink_left  = 0;
    int          sink_tick  = 0;

    always @(posedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_style <= sink_style_t'($urandom_range(0, 2));
            sink_left  <= $urandom_range(20, 120);
        end
        else
        begin
            sink_left <= sink_left - 1;
        end
        case (sink_style)
            SINK_STEADY:  rsp_ch.ready <= 1'b1;
            SINK_CHOPPY:  rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default:      rsp_ch.ready <= ((sink_tick % 5) < 3);
        endcase
        sink_tick <= sink_tick + 1;
    end

    // Watchdog: a run where nothing moves for too long has hung.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        request_mix_t mix;
        int           sent;
        int           phase_len;
        int           burst_len;
        int           i;

        rst_n                = 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.action       <= ACT_INSERT;
        req_ch.priority_req <= '0;
        req_ch.payload      <= '0;

        // Reset is asserted at the start and released once.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening. A delete on the empty queue must report empty.
        issue_request(ACT_DELETE, 8'hFF, 16'hFFFF);
        // Extreme priorities and payloads, then ties at the middle, at the
        // bottom and at the top, which must keep their arrival order.
        issue_request(ACT_INSERT, 8'h00, 16'h0000);
        issue_request(ACT_INSERT, 8'hFF, 16'hFFFF);
        issue_request(ACT_INSERT, 8'h80, 16'h1234);
        issue_request(ACT_INSERT, 8'h80, 16'h5678);
        issue_request(ACT_INSERT, 8'h80, 16'h9ABC);
        issue_request(ACT_INSERT, 8'h00, 16'h0001);
        issue_request(ACT_INSERT, 8'hFF, 16'h8001);
        // Fill the rest of the queue with alternating bit patterns.
        for (i = 0; i < QUEUE_DEPTH - 7; i++)
            issue_request(ACT_INSERT, (i % 2) ? 8'hAA : 8'h55, 16'hA5A0 + DATA_W'(i));
        // The queue is now full: this insert must be rejected and nothing stored.
        issue_request(ACT_INSERT, 8'hFF, 16'hDEAD);
        // A few deletes take the highest entries, ties in arrival order.
        repeat (4) issue_request(ACT_DELETE, 8'h00, 16'h0000);

        // Pause until every response of the opening has been taken.
        wait_until_drained();

        // Random part: phases of one request mix, each sent in bursts. Some phases
        // run back to back with no gaps, others leave random gaps between bursts.
        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            mix       = request_mix_t'($urandom_range(0, 2));
            phase_len = $urandom_range(15, 60);
            if ($urandom_range(0, 3) == 0)
            begin
                repeat (phase_len) issue_random_request(mix);
                sent += phase_len;
            end
            else
            begin
                while (phase_len > 0)
                begin
                    burst_len = $urandom_range(1, 12);
                    if (burst_len > phase_len)
                        burst_len = phase_len;
                    repeat (burst_len) issue_random_request(mix);
                    phase_len -= burst_len;
                    sent      += burst_len;
                    hold_off($urandom_range(0, 6));
                end
            end
            // Now and then the sender waits for the block to catch up completely.
            if ($urandom_range(0, 4) == 0)
                wait_until_drained();
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
